### rtl/dbt_pkg.sv
// Shared types, constants and codes of the double-buffered dirty bitmap tracker.
// Used by every module of the tracker; depends on nothing.
`timescale 1ns / 1ps

package dbt_pkg;

  // Sizes
  localparam int MAX_SERVERS   = 8;
  localparam int SRV_W         = $clog2(MAX_SERVERS);
  localparam int BANKS         = MAX_SERVERS * 2;
  localparam int BANK_W        = SRV_W + 1;
  localparam int GROUPS        = 64;
  localparam int GROUP_W       = $clog2(GROUPS);
  localparam int GROUP_ENTRIES = 32;
  localparam int REL_W         = $clog2(GROUP_ENTRIES);
  localparam int ENTRY_W       = 11;
  localparam int MAX_RESULTS   = 64;
  localparam int RES_W         = $clog2(MAX_RESULTS);
  localparam int GCNT_W        = $clog2(GROUPS + 1);
  localparam int MEM_DEPTH     = BANKS * GROUPS;
  localparam int MEM_AW        = BANK_W + GROUP_W;
  localparam int HDR_BYTES     = 8;
  localparam int SLICE_W       = 16;
  localparam int STEP_W        = $clog2(SLICE_W);

  // Operation codes
  localparam logic [1:0] OP_MARK   = 2'd0;
  localparam logic [1:0] OP_SWITCH = 2'd1;
  localparam logic [1:0] OP_SCAN   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SECTION = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SERVER_COUNT = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS   = 2'd1;
  localparam logic [1:0] CFG_BUFFER_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] slice;
    logic [31:0] obj_hash;
    logic [6:0]  server;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] section_base;
    logic [3:0]  byte_mask;
    logic [31:0] packed_bytes;
    logic [2:0]  byte_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [3:0]  server_count;
    logic [3:0]  index_bits;
    logic [11:0] buffer_limit;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic               bad;
    logic [SRV_W-1:0]   server;
    logic [GROUP_W-1:0] group;
    logic [REL_W-1:0]   rel;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_MARK_WR,
    B_SW_CLR,
    B_SW_DONE,
    B_SCAN_TEST,
    B_SCAN_DATA
  } back_state_t;

endpackage

### rtl/double_buffered_dirty_bitmap_tracker.sv
// Dirty bitmap tracker: a mark first runs the slice modulo, a switch clears the
// 64-word inactive bank, and a bad, unused or empty request is answered directly;
// a scan walks the groups and reads each dirty one.
// Input takes a new request only after the last one is handed on to the queue.
// Reset is synchronous; afterwards a pass over all 1024 words clears the child word
// memory with full held high. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module double_buffered_dirty_bitmap_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dbt_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output dbt_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data
);

  dbt_pkg::cfg_t cfg;
  dbt_pkg::cmd_t f_cmd, q_cmd;
  logic          cmd_push, cmd_pop, cmd_full, cmd_empty, clearing;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.server_count <= 4'd1;
      cfg.index_bits   <= 4'd11;
      cfg.buffer_limit <= 12'd2048;
    end else if (cfg_valid) begin
      if (cfg_index == dbt_pkg::CFG_SERVER_COUNT) cfg.server_count <= cfg_data[3:0];
      if (cfg_index == dbt_pkg::CFG_INDEX_BITS)   cfg.index_bits   <= cfg_data[3:0];
      if (cfg_index == dbt_pkg::CFG_BUFFER_LIMIT) cfg.buffer_limit <= cfg_data;
    end
  end

  dbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cfg      (cfg),
    .clearing (clearing),
    .cmd_push (cmd_push),
    .cmd      (f_cmd),
    .cmd_full (cmd_full)
  );

  dbt_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_cmd  (f_cmd),
    .q_full  (cmd_full),
    .rd      (cmd_pop),
    .rd_cmd  (q_cmd),
    .q_empty (cmd_empty)
  );

  dbt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_cmd    (q_cmd),
    .q_empty  (cmd_empty),
    .cmd_pop  (cmd_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  // Queue is never written full or read empty
  a_q_push: assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command queue overrun");
  a_q_pop: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !cmd_empty)
    else $error("command queue underrun");
  // A taken request holds the front busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst) (push && !full) |=> full)
    else $error("front accepted a second request too early");
  // No request is taken during the clearing pass
  a_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("request taken while clearing");

endmodule

### rtl/dbt_front.sv
// Front end: accepts requests, resolves server and entry, hands commands on.
// Depends on dbt_pkg.
`timescale 1ns / 1ps

module dbt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dbt_pkg::request_t request,
  input  dbt_pkg::cfg_t     cfg,
  input  logic              clearing,
  output logic              cmd_push,
  output dbt_pkg::cmd_t     cmd,
  input  logic              cmd_full
);

  dbt_pkg::front_state_t            state, state_next;
  logic [dbt_pkg::SLICE_W-1:0]      sl;
  logic [3:0]                       rem, rem_next;
  logic [dbt_pkg::STEP_W-1:0]       step;
  logic [dbt_pkg::ENTRY_W-1:0]      entry;
  logic [4:0]                       trial;
  logic                             accept;
  logic                             srv_bad;

  assign full   = (state != dbt_pkg::F_IDLE) || clearing;
  assign accept = push && !full;

  // Mask hash to the configured index width
  always_comb begin
    for (int i = 0; i < dbt_pkg::ENTRY_W; i++) begin
      entry[i] = request.obj_hash[i] && (4'(i) < cfg.index_bits);
    end
  end

  assign srv_bad = (request.server >= {3'b0, cfg.server_count})
                || (request.server >= 7'(dbt_pkg::MAX_SERVERS));

  // One restoring step of slice modulo server_count
  always_comb begin
    trial = {rem, sl[dbt_pkg::SLICE_W-1]};
    if (trial >= {1'b0, cfg.server_count}) begin
      rem_next = 4'(trial - {1'b0, cfg.server_count});
    end else begin
      rem_next = trial[3:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbt_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and push
  always_comb begin
    state_next = state;
    cmd_push   = 1'b0;
    unique case (state)
      dbt_pkg::F_IDLE: begin
        if (accept) begin
          if (request.operation == dbt_pkg::OP_MARK && cfg.server_count != 4'd0) begin
            state_next = dbt_pkg::F_DIV;
          end else begin
            state_next = dbt_pkg::F_PUSH;
          end
        end
      end
      dbt_pkg::F_DIV: begin
        if (step == '1) begin
          state_next = dbt_pkg::F_PUSH;
        end
      end
      dbt_pkg::F_PUSH: begin
        cmd_push = !cmd_full;
        if (!cmd_full) begin
          state_next = dbt_pkg::F_IDLE;
        end
      end
      default: state_next = dbt_pkg::F_IDLE;
    endcase
  end

  // Capture and classify the request, run the modulo
  always_ff @(posedge clk) begin
    if (state == dbt_pkg::F_IDLE && accept) begin
      cmd.op    <= request.operation;
      cmd.group <= entry[dbt_pkg::ENTRY_W-1:dbt_pkg::REL_W];
      cmd.rel   <= entry[dbt_pkg::REL_W-1:0];
      sl        <= request.slice;
      rem       <= 4'd0;
      step      <= '0;
      if (request.operation == dbt_pkg::OP_MARK) begin
        cmd.bad    <= (cfg.server_count == 4'd0);
        cmd.server <= '0;
      end else if (request.operation == dbt_pkg::OP_NONE) begin
        cmd.bad    <= 1'b0;
        cmd.server <= '0;
      end else begin
        cmd.bad    <= srv_bad;
        cmd.server <= request.server[dbt_pkg::SRV_W-1:0];
      end
    end else if (state == dbt_pkg::F_DIV) begin
      rem  <= rem_next;
      sl   <= {sl[dbt_pkg::SLICE_W-2:0], 1'b0};
      step <= step + 1'b1;
      if (step == '1) begin
        cmd.server <= rem_next[dbt_pkg::SRV_W-1:0];
        cmd.bad    <= (rem_next >= 4'(dbt_pkg::MAX_SERVERS));
      end
    end
  end

endmodule

### rtl/dbt_cmd_queue.sv
// Two-entry command queue between front and back.
// Depends on dbt_pkg.
`timescale 1ns / 1ps

module dbt_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dbt_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd,
  output dbt_pkg::cmd_t rd_cmd,
  output logic          q_empty
);

  dbt_pkg::cmd_t slots [2];
  logic          wp, rp;
  logic [1:0]    fill;

  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);
  assign rd_cmd  = slots[rp];

  // Store requests
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_cmd;
    end
  end

  // Advance pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      if (wr && !rd) fill <= fill + 2'd1;
      else if (rd && !wr) fill <= fill - 2'd1;
    end
  end

endmodule

### rtl/dbt_back.sv
// Back end: bitmaps, child word memory, bank switch and scan sequencer,
// and the result register. Depends on dbt_pkg.
`timescale 1ns / 1ps

module dbt_back (
  input  logic            clk,
  input  logic            rst,
  input  dbt_pkg::cfg_t   cfg,
  input  dbt_pkg::cmd_t   q_cmd,
  input  logic            q_empty,
  output logic            cmd_pop,
  output logic            clearing,
  output logic            empty,
  input  logic            pop,
  output dbt_pkg::result_t result
);

  dbt_pkg::back_state_t          state, state_next;
  dbt_pkg::cmd_t                 cmd;
  logic                          active [dbt_pkg::MAX_SERVERS];
  logic [dbt_pkg::GROUPS-1:0]    gbits  [dbt_pkg::BANKS];
  logic [dbt_pkg::GCNT_W-1:0]    gcnt   [dbt_pkg::BANKS];
  logic [31:0]                   mem    [dbt_pkg::MEM_DEPTH];
  logic [31:0]                   rdata;
  logic [dbt_pkg::MEM_AW-1:0]    clr, clr_next;
  logic [dbt_pkg::GROUP_W-1:0]   g, g_next;
  logic [dbt_pkg::RES_W-1:0]     n, n_next;
  logic [11:0]                   pos, pos_next;
  logic                          out_valid;
  logic                          emit;
  dbt_pkg::result_t              emit_item;
  logic                          mem_we, rd_en;
  logic [dbt_pkg::MEM_AW-1:0]    waddr, raddr;
  logic [31:0]                   wdata;
  logic                          gbit_set, gbit_clr, bank_clr, flip, take;
  logic [dbt_pkg::BANK_W-1:0]    mb, ib, q_mb, q_ib;
  // section packing
  logic [11:0]                   p;
  logic                          tb;
  logic [3:0]                    bmask;
  logic [31:0]                   pk;
  logic [2:0]                    bcnt;
  logic [7:0]                    byt;

  assign clearing = (state == dbt_pkg::B_CLEAR);
  assign empty    = !out_valid;
  assign mb   = {cmd.server, active[cmd.server]};
  assign ib   = {cmd.server, ~active[cmd.server]};
  assign q_mb = {q_cmd.server, active[q_cmd.server]};
  assign q_ib = {q_cmd.server, ~active[q_cmd.server]};

  // Pack the nonzero bytes of the child word against the byte budget
  always_comb begin
    p     = pos + 12'(dbt_pkg::HDR_BYTES);
    tb    = 1'b0;
    bmask = 4'd0;
    pk    = 32'd0;
    bcnt  = 3'd0;
    byt   = 8'd0;
    for (int i = 0; i < 4; i++) begin
      byt = rdata[8*i +: 8];
      if (byt != 8'd0 && !tb) begin
        if (p >= cfg.buffer_limit) begin
          tb = 1'b1;
        end else begin
          bmask[i] = 1'b1;
          pk       = pk | (32'(byt) << {bcnt, 3'b000});
          bcnt     = bcnt + 3'd1;
          p        = p + 12'd1;
        end
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbt_pkg::B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    clr_next   = clr;
    g_next     = g;
    n_next     = n;
    pos_next   = pos;
    cmd_pop    = 1'b0;
    take       = 1'b0;
    mem_we     = 1'b0;
    waddr      = '0;
    wdata      = 32'd0;
    rd_en      = 1'b0;
    raddr      = '0;
    emit       = 1'b0;
    emit_item  = '0;
    emit_item.last = 1'b1;
    gbit_set   = 1'b0;
    gbit_clr   = 1'b0;
    bank_clr   = 1'b0;
    flip       = 1'b0;
    unique case (state)
      dbt_pkg::B_CLEAR: begin
        mem_we   = 1'b1;
        waddr    = clr;
        clr_next = clr + 1'b1;
        if (clr == '1) state_next = dbt_pkg::B_IDLE;
      end
      dbt_pkg::B_IDLE: begin
        if (!q_empty && !out_valid) begin
          cmd_pop = 1'b1;
          take    = 1'b1;
          if (q_cmd.bad) begin
            emit             = 1'b1;
            emit_item.status = dbt_pkg::ST_BAD;
          end else if (q_cmd.op == dbt_pkg::OP_MARK) begin
            rd_en      = 1'b1;
            raddr      = {q_mb, q_cmd.group};
            state_next = dbt_pkg::B_MARK_WR;
          end else if (q_cmd.op == dbt_pkg::OP_SWITCH) begin
            g_next     = '0;
            state_next = dbt_pkg::B_SW_CLR;
          end else if (q_cmd.op == dbt_pkg::OP_SCAN && gcnt[q_ib] != '0) begin
            g_next     = '0;
            n_next     = '0;
            pos_next   = 12'd0;
            state_next = dbt_pkg::B_SCAN_TEST;
          end else begin
            emit             = 1'b1;
            emit_item.status = dbt_pkg::ST_DONE;
          end
        end
      end
      dbt_pkg::B_MARK_WR: begin
        if (!out_valid) begin
          mem_we     = 1'b1;
          waddr      = {mb, cmd.group};
          wdata      = rdata | (32'd1 << cmd.rel);
          gbit_set   = 1'b1;
          emit       = 1'b1;
          state_next = dbt_pkg::B_IDLE;
        end
      end
      dbt_pkg::B_SW_CLR: begin
        mem_we = 1'b1;
        waddr  = {ib, g};
        g_next = g + 1'b1;
        if (g == '1) state_next = dbt_pkg::B_SW_DONE;
      end
      dbt_pkg::B_SW_DONE: begin
        if (!out_valid) begin
          bank_clr   = 1'b1;
          flip       = 1'b1;
          emit       = 1'b1;
          state_next = dbt_pkg::B_IDLE;
        end
      end
      dbt_pkg::B_SCAN_TEST: begin
        if (gbits[ib][g]) begin
          gbit_clr   = 1'b1;
          rd_en      = 1'b1;
          raddr      = {ib, g};
          state_next = dbt_pkg::B_SCAN_DATA;
        end else if (g == '1) begin
          if (n != '0) begin
            state_next = dbt_pkg::B_IDLE;
          end else if (!out_valid) begin
            emit       = 1'b1;
            state_next = dbt_pkg::B_IDLE;
          end
        end else begin
          g_next = g + 1'b1;
        end
      end
      dbt_pkg::B_SCAN_DATA: begin
        if (!out_valid) begin
          emit     = 1'b1;
          pos_next = p;
          if (tb || (n == '1 && gcnt[ib] != '0)) begin
            emit_item.status = dbt_pkg::ST_TOO_BIG;
            state_next       = dbt_pkg::B_IDLE;
          end else begin
            emit_item.status       = dbt_pkg::ST_SECTION;
            emit_item.section_base = {g, dbt_pkg::REL_W'(0)};
            emit_item.byte_mask    = bmask;
            emit_item.packed_bytes = pk;
            emit_item.byte_count   = bcnt;
            emit_item.last         = (gcnt[ib] == '0);
            n_next                 = n + 1'b1;
            if (gcnt[ib] == '0 || g == '1) begin
              state_next = dbt_pkg::B_IDLE;
            end else begin
              g_next     = g + 1'b1;
              state_next = dbt_pkg::B_SCAN_TEST;
            end
          end
        end
      end
      default: state_next = dbt_pkg::B_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else begin
      clr <= clr_next;
    end
    g   <= g_next;
    n   <= n_next;
    pos <= pos_next;
    if (take) cmd <= q_cmd;
  end

  // Child word memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // Parent bitmaps, group counts and active banks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < dbt_pkg::MAX_SERVERS; s++) active[s] <= 1'b0;
      for (int b = 0; b < dbt_pkg::BANKS; b++) begin
        gbits[b] <= '0;
        gcnt[b]  <= '0;
      end
    end else begin
      if (gbit_set && !gbits[mb][cmd.group]) begin
        gbits[mb][cmd.group] <= 1'b1;
        gcnt[mb]             <= gcnt[mb] + 1'b1;
      end
      if (gbit_clr) begin
        gbits[ib][g] <= 1'b0;
        gcnt[ib]     <= gcnt[ib] - 1'b1;
      end
      if (bank_clr) begin
        gbits[ib] <= '0;
        gcnt[ib]  <= '0;
      end
      if (flip) active[cmd.server] <= ~active[cmd.server];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
    if (emit) result <= emit_item;
  end

endmodule

### dv/tb_double_buffered_dirty_bitmap_tracker.sv
// Self-checking testbench of the double-buffered dirty bitmap tracker.
// Predicts every result from its own model of the banks; needs rtl/dbt_pkg.sv and the tracker.
`timescale 1ns / 1ps

module tb_double_buffered_dirty_bitmap_tracker;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  dbt_pkg::request_t request = '0;
  logic              empty;
  logic              pop = 1'b0;
  dbt_pkg::result_t  result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = dbt_pkg::CFG_SERVER_COUNT;
  logic [11:0]       cfg_data = '0;

  double_buffered_dirty_bitmap_tracker i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tracker image kept by the testbench
  logic [3:0]  n_servers  = 4'd1;
  logic [3:0]  idx_width  = 4'd11;
  logic [11:0] byte_budget = 12'd2048;
  logic        cur_bank [dbt_pkg::MAX_SERVERS];
  logic [63:0] group_map [dbt_pkg::BANKS];
  int          group_tally [dbt_pkg::BANKS];
  logic [31:0] entry_map [dbt_pkg::BANKS][dbt_pkg::GROUPS];

  dbt_pkg::request_t pending_reqs[$];
  dbt_pkg::result_t  awaited_results[$];
  int       idle_pct = 19;
  int       errors = 0;
  int       cycles = 0;

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic dbt_pkg::result_t status_only(logic [1:0] st);
    dbt_pkg::result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Work out the results of one accepted request
  task automatic predict_results(dbt_pkg::request_t q);
    int unsigned s, entry, g, b, w, pos, n, mask, packed_val, cnt, bt;
    dbt_pkg::result_t r;
    case (q.operation)
      dbt_pkg::OP_MARK: begin
        if (n_servers == 0) begin
          awaited_results.push_back(status_only(dbt_pkg::ST_BAD));
          return;
        end
        s = q.slice % n_servers;
        if (s >= dbt_pkg::MAX_SERVERS) begin
          awaited_results.push_back(status_only(dbt_pkg::ST_BAD));
          return;
        end
        entry = q.obj_hash & ((32'd1 << idx_width) - 32'd1);
        g = (entry / dbt_pkg::GROUP_ENTRIES) % dbt_pkg::GROUPS;
        b = s * 2 + cur_bank[s];
        if (!group_map[b][g]) begin
          group_map[b][g] = 1'b1;
          group_tally[b]++;
        end
        entry_map[b][g][entry % dbt_pkg::GROUP_ENTRIES] = 1'b1;
        awaited_results.push_back(status_only(dbt_pkg::ST_DONE));
      end
      dbt_pkg::OP_SWITCH: begin
        if (q.server >= n_servers || q.server >= dbt_pkg::MAX_SERVERS) begin
          awaited_results.push_back(status_only(dbt_pkg::ST_BAD));
          return;
        end
        b = q.server * 2 + (1 - cur_bank[q.server]);
        group_map[b] = '0;
        group_tally[b] = 0;
        for (int i = 0; i < dbt_pkg::GROUPS; i++) entry_map[b][i] = '0;
        cur_bank[q.server] = !cur_bank[q.server];
        awaited_results.push_back(status_only(dbt_pkg::ST_DONE));
      end
      dbt_pkg::OP_SCAN: begin
        if (q.server >= n_servers || q.server >= dbt_pkg::MAX_SERVERS) begin
          awaited_results.push_back(status_only(dbt_pkg::ST_BAD));
          return;
        end
        b = q.server * 2 + (1 - cur_bank[q.server]);
        pos = 0;
        n = 0;
        for (g = 0; g < dbt_pkg::GROUPS && group_tally[b] != 0; g++) begin
          if (!group_map[b][g]) continue;
          group_map[b][g] = 1'b0;
          group_tally[b]--;
          w = entry_map[b][g];
          pos += dbt_pkg::HDR_BYTES;
          mask = 0;
          packed_val = 0;
          cnt = 0;
          for (int i = 0; i < 4; i++) begin
            bt = (w >> (8 * i)) & 8'hFF;
            if (bt == 0) continue;
            if (pos >= byte_budget) begin
              awaited_results.push_back(status_only(dbt_pkg::ST_TOO_BIG));
              return;
            end
            mask |= 1 << i;
            packed_val |= bt << (8 * cnt);
            cnt++;
            pos++;
          end
          // Cap the section count of one scan
          if (n == dbt_pkg::MAX_RESULTS - 1 && group_tally[b] != 0) begin
            awaited_results.push_back(status_only(dbt_pkg::ST_TOO_BIG));
            return;
          end
          r = '0;
          r.status = dbt_pkg::ST_SECTION;
          r.section_base = 11'(g * dbt_pkg::GROUP_ENTRIES);
          r.byte_mask = 4'(mask);
          r.packed_bytes = packed_val;
          r.byte_count = 3'(cnt);
          r.last = (group_tally[b] == 0);
          awaited_results.push_back(r);
          n++;
        end
        if (n == 0) awaited_results.push_back(status_only(dbt_pkg::ST_DONE));
      end
      default: awaited_results.push_back(status_only(dbt_pkg::ST_DONE));
    endcase
  endtask

  // Driver: present queued requests, idling at random
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_results(request);
      if (!push || !full) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          request <= pending_reqs.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pop at random and check against the oldest expectation
  always @(posedge clk) begin
    dbt_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report($sformatf("unexpected result %p", result));
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status)
            report($sformatf("status %0d, want %0d", result.status, want.status));
          if (result.section_base !== want.section_base)
            report($sformatf("section_base %0d, want %0d", result.section_base,
                             want.section_base));
          if (result.byte_mask !== want.byte_mask)
            report($sformatf("byte_mask %h, want %h", result.byte_mask, want.byte_mask));
          if (result.packed_bytes !== want.packed_bytes)
            report($sformatf("packed_bytes %h, want %h", result.packed_bytes,
                             want.packed_bytes));
          if (result.byte_count !== want.byte_count)
            report($sformatf("byte_count %0d, want %0d", result.byte_count,
                             want.byte_count));
          if (result.last !== want.last)
            report($sformatf("last %0d, want %0d", result.last, want.last));
        end
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[double_buffered_dirty_bitmap_tracker] ERROR");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] op, logic [15:0] sl, logic [31:0] h, logic [6:0] sv);
    dbt_pkg::request_t q;
    q.operation = op;
    q.slice = sl;
    q.obj_hash = h;
    q.server = sv;
    pending_reqs.push_back(q);
  endtask

  // Slice that lands on server s under the current count
  function automatic logic [15:0] slice_for(int s);
    int unsigned v;
    v = $urandom_range(65535);
    if (n_servers != 0) v = v - v % n_servers + s;
    return 16'(v);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || push || awaited_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Hold valid high across back-to-back writes; configure drops it after the last
  task automatic cfg_write(logic [1:0] idx, logic [11:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dbt_pkg::CFG_SERVER_COUNT: n_servers = d[3:0];
      dbt_pkg::CFG_INDEX_BITS:   idx_width = d[3:0];
      dbt_pkg::CFG_BUFFER_LIMIT: byte_budget = d;
      default: ;
    endcase
  endtask

  task automatic configure(int cnt, int ib, int lim);
    wait_idle();
    cfg_write(dbt_pkg::CFG_SERVER_COUNT, 12'(cnt));
    cfg_write(dbt_pkg::CFG_INDEX_BITS, 12'(ib));
    cfg_write(dbt_pkg::CFG_BUFFER_LIMIT, 12'(lim));
    cfg_valid <= 1'b0;
  endtask

  // Mostly mark/switch/scan runs on live servers, with some noise
  task automatic random_requests(int total);
    int made, s, k;
    made = 0;
    while (made < total) begin
      s = (n_servers == 0) ? 0 : $urandom_range(n_servers - 1);
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(8, 1);
        repeat (k) add_req(dbt_pkg::OP_MARK, slice_for(s), $urandom, 7'($urandom));
        add_req(dbt_pkg::OP_SWITCH, 16'($urandom), $urandom, 7'(s));
        add_req(dbt_pkg::OP_SCAN, 16'($urandom), $urandom, 7'(s));
        made += k + 2;
      end else begin
        add_req(2'($urandom_range(3)), 16'($urandom), $urandom,
                ($urandom_range(3) == 0) ? 7'($urandom) : 7'(s));
        made++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < dbt_pkg::MAX_SERVERS; i++) cur_bank[i] = 1'b0;
    for (int i = 0; i < dbt_pkg::BANKS; i++) begin
      group_map[i] = '0;
      group_tally[i] = 0;
      for (int j = 0; j < dbt_pkg::GROUPS; j++) entry_map[i][j] = '0;
    end

    // Directed: field extremes, every operation, nothing dirty, bad server
    add_req(dbt_pkg::OP_MARK, 16'h0000, 32'h0000_0000, 7'h00);
    add_req(dbt_pkg::OP_MARK, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F);
    add_req(dbt_pkg::OP_MARK, 16'h1234, 32'h0000_0421, 7'h00);
    add_req(dbt_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h00);
    add_req(dbt_pkg::OP_SWITCH, 16'h0, 32'h0, 7'h00);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h00);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h00);
    add_req(dbt_pkg::OP_SWITCH, 16'h0, 32'h0, 7'h7F);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h01);
    configure(0, 11, 2048);
    add_req(dbt_pkg::OP_MARK, 16'h0005, 32'h0000_0010, 7'h00);
    add_req(dbt_pkg::OP_SWITCH, 16'h0, 32'h0, 7'h00);
    // Too big: two groups, budget runs out in the second
    configure(2, 11, 16);
    add_req(dbt_pkg::OP_MARK, 16'h0001, 32'h0000_0001, 7'h00);
    add_req(dbt_pkg::OP_MARK, 16'h0001, 32'h0000_0019, 7'h00);
    add_req(dbt_pkg::OP_MARK, 16'h0001, 32'h0000_0022, 7'h00);
    add_req(dbt_pkg::OP_MARK, 16'h0001, 32'h0000_003F, 7'h00);
    add_req(dbt_pkg::OP_SWITCH, 16'h0, 32'h0, 7'h01);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h01);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h01);

    // Every group dirty: a full 64-section scan, then an empty one
    configure(8, 11, 4095);
    idle_pct = 0;
    for (int g = 0; g < dbt_pkg::GROUPS; g++)
      add_req(dbt_pkg::OP_MARK, slice_for(3),
              32'(g * dbt_pkg::GROUP_ENTRIES + $urandom_range(31)), 7'h00);
    add_req(dbt_pkg::OP_SWITCH, 16'h0, 32'h0, 7'h03);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h03);
    add_req(dbt_pkg::OP_SCAN, 16'h0, 32'h0, 7'h03);
    random_requests(25);
    wait_idle();
    idle_pct = 19;

    configure(3, 7, 16);
    random_requests(45);
    configure(15, 15, 100);
    random_requests(45);
    configure(1, 0, 40);
    random_requests(30);
    configure(5, 5, 0);
    random_requests(30);
    configure(8, 9, 300);
    random_requests(50);
    configure(7, 11, 2048);
    random_requests(50);

    wait_idle();
    if (errors == 0) begin
      $display("[double_buffered_dirty_bitmap_tracker] OK");
    end else begin
      $display("[double_buffered_dirty_bitmap_tracker] ERROR");
    end
    $finish;
  end

endmodule
